@@ rtl/tlik_pkg.sv @@
// Shared types, constants and the arctangent table for the two-link inverse kinematics block.
package tlik_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int CORDIC_MAX_ITER       = 24;

    // Vector datapath width: normalized vectors sit below 2^49 and grow by the CORDIC gain.
    localparam int VW = 53;
    // Angle width in units of 2^-20 degree.
    localparam int AW = 32;
    // Multiplier operand width.
    localparam int MW = 34;

    localparam int LINK_W  = 15;
    localparam int COORD_W = 16;
    localparam int DRIVE_W = 8;
    localparam int HIP_W   = 16;
    localparam int KNEE_W  = 14;

    localparam logic signed [AW-1:0] HALF_TURN_ANG = AW'(188743680);
    localparam int QUARTER_TURN_64 = 5760;
    localparam int HALF_TURN_64    = 11520;
    localparam int ROUND_64        = 8192;
    localparam int FRAC_SHIFT      = 14;

    localparam logic [LINK_W-1:0] LINK_RESET = LINK_W'(1024);

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] z;
    } cordic_vec_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_XX,
        S_YY,
        S_A1SQ,
        S_A2SQ,
        S_A1A2,
        S_CHECK,
        S_NORM,
        S_DSQ,
        S_NSQ,
        S_DIFF,
        S_SQRT,
        S_VLOAD,
        S_VPREP,
        S_VNORM,
        S_VWAIT,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_OUT
    } ik_state_t;

    typedef enum logic [1:0] {
        VEC_ELBOW,
        VEC_TARGET,
        VEC_REACH
    } vec_sel_t;

    typedef enum logic {
        REG_UPPER = 1'b0,
        REG_LOWER = 1'b1
    } reg_index_t;

    // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
    function automatic logic signed [AW-1:0] atan_entry(input int idx);
        logic signed [AW-1:0] val;
        case (idx)
            0:  val = AW'(47185920);
            1:  val = AW'(27855475);
            2:  val = AW'(14718068);
            3:  val = AW'(7471121);
            4:  val = AW'(3750058);
            5:  val = AW'(1876857);
            6:  val = AW'(938658);
            7:  val = AW'(469357);
            8:  val = AW'(234682);
            9:  val = AW'(117342);
            10: val = AW'(58671);
            11: val = AW'(29335);
            12: val = AW'(14668);
            13: val = AW'(7334);
            14: val = AW'(3667);
            15: val = AW'(1833);
            16: val = AW'(917);
            17: val = AW'(458);
            18: val = AW'(229);
            19: val = AW'(115);
            20: val = AW'(57);
            21: val = AW'(29);
            22: val = AW'(14);
            23: val = AW'(7);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/tlik_cordic_cell.sv @@
// One CORDIC vectoring iteration with a fixed shift, registered toward the next cell.
module tlik_cordic_cell
    import tlik_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cordic_vec_t in_vec,
    output logic        out_valid,
    output cordic_vec_t out_vec
);

    localparam logic signed [AW-1:0] STEP_ANGLE = atan_entry(SHIFT);

    logic        valid_reg;
    cordic_vec_t vec_reg;
    cordic_vec_t vec_next;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    always_comb
    begin
        dx = in_vec.x >>> SHIFT;
        dy = in_vec.y >>> SHIFT;
        vec_next = in_vec;
        if (!in_vec.y[VW-1] && (in_vec.y != '0))
        begin
            vec_next.x = in_vec.x + dy;
            vec_next.y = in_vec.y - dx;
            vec_next.z = in_vec.z + STEP_ANGLE;
        end
        else if (in_vec.y[VW-1])
        begin
            vec_next.x = in_vec.x - dy;
            vec_next.y = in_vec.y + dx;
            vec_next.z = in_vec.z - STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

@@ rtl/tlik_cordic_chain.sv @@
// Row of CORDIC cells, each registered; a vector entering here leaves at the far end with its angle.
module tlik_cordic_chain
    import tlik_pkg::*;
#(
    parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cordic_vec_t in_vec,
    output logic        out_valid,
    output cordic_vec_t out_vec
);

    logic        valid_s [0:ITERATIONS];
    cordic_vec_t vec_s   [0:ITERATIONS];

    assign valid_s[0] = in_valid;
    assign vec_s[0]   = in_vec;

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        tlik_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_s[i]),
            .in_vec    (vec_s[i]),
            .out_valid (valid_s[i+1]),
            .out_vec   (vec_s[i+1])
        );
    end

    assign out_valid = valid_s[ITERATIONS];
    assign out_vec   = vec_s[ITERATIONS];

endmodule

@@ rtl/two_link_inverse_kinematics_top.sv @@
// Top level: sequencer, shared multiplier, square root and servo output registers.
//
// Inverse kinematics for a two-link planar leg. Each input transaction carries a target point
// in 1/16 mm and a drive level; one output transaction returns hip and knee servo angles in
// 1/64 degree, the drive level and an out-of-reach flag. Items are handled one at a time. An
// item goes through the multiplies and the range check, normalizes the link product, forms
// the squared sine term, takes a bit-serial square root and makes three arctangent passes.
// Each pass has setup, normalizing shifts and a trip through the row of CORDIC cells; a zero
// vector ends its pass in setup. An item can then wait until the output is free to take its
// result. An out of reach target skips the square root and the passes and repeats the last
// angles. A new item is taken while the previous result still waits at the output. Link
// lengths are written over the APB port at byte addresses 0 and 4 and should only change
// while the block is idle.
module two_link_inverse_kinematics_top
    import tlik_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] target_x,
    input  logic signed [COORD_W-1:0] target_y,
    input  logic [DRIVE_W-1:0]        drive_level,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [HIP_W-1:0]   hip_angle,
    output logic signed [KNEE_W-1:0]  knee_angle,
    output logic [DRIVE_W-1:0]        drive_out,
    output logic                      unreachable
);

    localparam logic signed [MW-1:0] DEN_LIMIT   = MW'(64'sd1 << 30);
    localparam logic signed [MW-1:0] DEN_LIMIT4  = MW'(64'sd1 << 26);
    localparam logic [VW-2:0]        MAG_TARGET  = (VW-1)'(64'd1 << 48);
    localparam logic [VW-2:0]        MAG_COARSE  = (VW-1)'(64'd1 << 44);

    ik_state_t state_reg, state_next;

    logic [LINK_W-1:0] upper_reg, lower_reg;

    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [DRIVE_W-1:0]        drive_reg;
    logic signed [MW-1:0]      acc_reg, num_reg, den_reg;
    logic signed [63:0]        prod_reg;
    logic [63:0]               sq_reg, root_reg;
    logic [4:0]                k_reg;
    vec_sel_t                  vsel_reg;
    logic signed [VW-1:0]      vx_reg, vy_reg;
    logic signed [AW-1:0]      vz_reg;
    logic signed [AW-1:0]      ang_elbow_reg, ang_target_reg, ang_reach_reg;
    logic                      unreach_reg;

    logic signed [HIP_W-1:0]  held_hip_reg;
    logic signed [KNEE_W-1:0] held_knee_reg;
    logic [DRIVE_W-1:0]       drive_out_reg;
    logic                     unreachable_reg;
    logic                     out_valid_reg;

    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] prod_c;
    logic signed [MW-1:0]   den_c;
    logic                   unreach_c;
    logic [63:0]            sqrt_bit, sqrt_trial;
    logic [VW-2:0]          abs_x, abs_y, mag;
    logic                   vec_zero;
    logic                   vec_finish;
    logic signed [AW-1:0]   vec_result;
    logic                   out_free;
    logic                   launch;
    logic                   apb_write;

    cordic_vec_t chain_in, chain_out;
    logic        chain_out_valid;

    logic signed [AW-1:0]          elbow_rnd, reach_diff;
    logic signed [AW-FRAC_SHIFT-1:0] q2, q1;
    logic signed [AW-FRAC_SHIFT-1:0] q2_clamped;
    logic signed [AW-FRAC_SHIFT:0]   hip_wide;
    logic signed [HIP_W-1:0]       hip_c;
    logic signed [KNEE_W-1:0]      knee_c;

    // Configuration port
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;
    assign prdata    = (reg_index_t'(paddr[2]) == REG_LOWER) ? 32'(lower_reg) : 32'(upper_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= LINK_RESET;
            lower_reg <= LINK_RESET;
        end
        else if (apb_write)
        begin
            case (reg_index_t'(paddr[2]))
                REG_UPPER: upper_reg <= pwdata[LINK_W-1:0];
                REG_LOWER: lower_reg <= pwdata[LINK_W-1:0];
                default:   upper_reg <= upper_reg;
            endcase
        end
    end

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_XX:
            begin
                mul_a = MW'(x_reg);
                mul_b = MW'(x_reg);
            end
            S_YY:
            begin
                mul_a = MW'(y_reg);
                mul_b = MW'(y_reg);
            end
            S_A1SQ:
            begin
                mul_a = signed'(MW'(upper_reg));
                mul_b = signed'(MW'(upper_reg));
            end
            S_A2SQ:
            begin
                mul_a = signed'(MW'(lower_reg));
                mul_b = signed'(MW'(lower_reg));
            end
            S_A1A2:
            begin
                mul_a = signed'(MW'(upper_reg));
                mul_b = signed'(MW'(lower_reg));
            end
            S_DSQ:
            begin
                mul_a = den_reg;
                mul_b = den_reg;
            end
            S_NSQ:
            begin
                mul_a = num_reg;
                mul_b = num_reg;
            end
            S_P1:
            begin
                mul_a = signed'(MW'(lower_reg));
                mul_b = signed'(MW'(root_reg[31:0]));
            end
            S_P2:
            begin
                mul_a = signed'(MW'(upper_reg));
                mul_b = den_reg;
            end
            S_P3:
            begin
                mul_a = signed'(MW'(lower_reg));
                mul_b = num_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    assign den_c     = signed'({prod_reg[MW-2:0], 1'b0});
    assign unreach_c = (den_c == '0) || (acc_reg > den_c) || (acc_reg < -den_c);

    assign sqrt_bit   = 64'd1 << {k_reg, 1'b0};
    assign sqrt_trial = root_reg + sqrt_bit;

    assign abs_x    = vx_reg[VW-1] ? (VW-1)'(-vx_reg) : vx_reg[VW-2:0];
    assign abs_y    = vy_reg[VW-1] ? (VW-1)'(-vy_reg) : vy_reg[VW-2:0];
    assign mag      = (abs_x > abs_y) ? abs_x : abs_y;
    assign vec_zero = (vx_reg == '0) && (vy_reg == '0);

    assign out_free = !out_valid_reg || out_ready;

    // Angle resolution and servo frame offsets
    assign elbow_rnd  = ang_elbow_reg + AW'(ROUND_64);
    assign reach_diff = ang_target_reg - ang_reach_reg + AW'(ROUND_64);
    assign q2         = elbow_rnd[AW-1:FRAC_SHIFT];
    assign q1         = reach_diff[AW-1:FRAC_SHIFT];

    always_comb
    begin
        if (q2 < 0)
        begin
            q2_clamped = '0;
        end
        else if (q2 > (AW-FRAC_SHIFT)'(HALF_TURN_64))
        begin
            q2_clamped = (AW-FRAC_SHIFT)'(HALF_TURN_64);
        end
        else
        begin
            q2_clamped = q2;
        end
        knee_c   = KNEE_W'((AW-FRAC_SHIFT)'(QUARTER_TURN_64) - q2_clamped);
        hip_wide = (AW-FRAC_SHIFT+1)'(q1) - (AW-FRAC_SHIFT+1)'(QUARTER_TURN_64);
        if (hip_wide > (AW-FRAC_SHIFT+1)'(32767))
        begin
            hip_c = 16'sh7FFF;
        end
        else if (hip_wide < -(AW-FRAC_SHIFT+1)'(32768))
        begin
            hip_c = -16'sh8000;
        end
        else
        begin
            hip_c = HIP_W'(hip_wide);
        end
    end

    // Completion of one arctangent pass
    always_comb
    begin
        vec_finish = 1'b0;
        vec_result = '0;
        if ((state_reg == S_VPREP) && vec_zero)
        begin
            vec_finish = 1'b1;
        end
        else if ((state_reg == S_VWAIT) && chain_out_valid)
        begin
            vec_finish = 1'b1;
            vec_result = chain_out.z;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_XX;
            S_XX:    state_next = S_YY;
            S_YY:    state_next = S_A1SQ;
            S_A1SQ:  state_next = S_A2SQ;
            S_A2SQ:  state_next = S_A1A2;
            S_A1A2:  state_next = S_CHECK;
            S_CHECK: state_next = unreach_c ? S_OUT : S_NORM;
            S_NORM:  if (den_reg > DEN_LIMIT) state_next = S_DSQ;
            S_DSQ:   state_next = S_NSQ;
            S_NSQ:   state_next = S_DIFF;
            S_DIFF:  state_next = S_SQRT;
            S_SQRT:  if (k_reg == '0) state_next = S_VLOAD;
            S_VLOAD: state_next = S_VPREP;
            S_VPREP: state_next = S_VNORM;
            S_VNORM: if (mag >= MAG_TARGET) state_next = S_VWAIT;
            S_VWAIT: state_next = S_VWAIT;
            S_P1:    state_next = S_P2;
            S_P2:    state_next = S_P3;
            S_P3:    state_next = S_P4;
            S_P4:    state_next = S_VPREP;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (vec_finish)
        begin
            case (vsel_reg)
                VEC_ELBOW:  state_next = S_VLOAD;
                VEC_TARGET: state_next = S_P1;
                VEC_REACH:  state_next = S_OUT;
                default:    state_next = S_OUT;
            endcase
        end
    end

    // Handshake and launch outputs
    always_comb
    begin
        in_ready = 1'b0;
        launch   = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_VNORM: launch   = (mag >= MAG_TARGET);
            default:
            begin
                in_ready = 1'b0;
                launch   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            held_hip_reg    <= '0;
            held_knee_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (!unreach_reg)
                begin
                    held_hip_reg  <= hip_c;
                    held_knee_reg <= knee_c;
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_c[63:0];
        if ((state_reg == S_OUT) && out_free)
        begin
            drive_out_reg   <= drive_reg;
            unreachable_reg <= unreach_reg;
        end
        if (vec_finish)
        begin
            case (vsel_reg)
                VEC_ELBOW:  ang_elbow_reg  <= vec_result;
                VEC_TARGET: ang_target_reg <= vec_result;
                VEC_REACH:  ang_reach_reg  <= vec_result;
                default:    ang_reach_reg  <= vec_result;
            endcase
            if (vsel_reg == VEC_ELBOW)
            begin
                vsel_reg <= VEC_TARGET;
            end
            else if (vsel_reg == VEC_TARGET)
            begin
                vsel_reg <= VEC_REACH;
            end
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_reg     <= target_x;
                    y_reg     <= target_y;
                    drive_reg <= drive_level;
                end
            end
            S_YY:   acc_reg <= prod_reg[MW-1:0];
            S_A1SQ: acc_reg <= acc_reg + prod_reg[MW-1:0];
            S_A2SQ: acc_reg <= acc_reg - prod_reg[MW-1:0];
            S_A1A2: acc_reg <= acc_reg - prod_reg[MW-1:0];
            S_CHECK:
            begin
                num_reg     <= acc_reg;
                den_reg     <= den_c;
                unreach_reg <= unreach_c;
            end
            S_NORM:
            begin
                // Shifting by four or one place stops once the denominator exceeds 2^30.
                if (den_reg <= DEN_LIMIT4)
                begin
                    den_reg <= den_reg <<< 4;
                    num_reg <= num_reg <<< 4;
                end
                else if (den_reg <= DEN_LIMIT)
                begin
                    den_reg <= den_reg <<< 1;
                    num_reg <= num_reg <<< 1;
                end
            end
            S_NSQ:  sq_reg <= prod_reg;
            S_DIFF:
            begin
                sq_reg   <= sq_reg - prod_reg;
                root_reg <= '0;
                k_reg    <= '1;
                vsel_reg <= VEC_ELBOW;
            end
            S_SQRT:
            begin
                k_reg <= k_reg - 5'd1;
                if (sq_reg >= sqrt_trial)
                begin
                    sq_reg   <= sq_reg - sqrt_trial;
                    root_reg <= (root_reg >> 1) + sqrt_bit;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            S_VLOAD:
            begin
                if (vsel_reg == VEC_ELBOW)
                begin
                    vx_reg <= VW'(num_reg);
                    vy_reg <= signed'(VW'(root_reg[31:0]));
                end
                else
                begin
                    vx_reg <= VW'(x_reg);
                    vy_reg <= VW'(y_reg);
                end
            end
            S_VPREP:
            begin
                // Left half plane vectors are turned by half a turn first.
                if (vx_reg[VW-1])
                begin
                    vx_reg <= -vx_reg;
                    vy_reg <= -vy_reg;
                    vz_reg <= vy_reg[VW-1] ? -HALF_TURN_ANG : HALF_TURN_ANG;
                end
                else
                begin
                    vz_reg <= '0;
                end
            end
            S_VNORM:
            begin
                if (mag < MAG_COARSE)
                begin
                    vx_reg <= vx_reg <<< 4;
                    vy_reg <= vy_reg <<< 4;
                end
                else if (mag < MAG_TARGET)
                begin
                    vx_reg <= vx_reg <<< 1;
                    vy_reg <= vy_reg <<< 1;
                end
            end
            S_P2:   vy_reg <= prod_reg[VW-1:0];
            S_P3:   vx_reg <= prod_reg[VW-1:0];
            S_P4:   vx_reg <= vx_reg + prod_reg[VW-1:0];
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign chain_in.x = vx_reg;
    assign chain_in.y = vy_reg;
    assign chain_in.z = vz_reg;

    tlik_cordic_chain #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (launch),
        .in_vec    (chain_in),
        .out_valid (chain_out_valid),
        .out_vec   (chain_out)
    );

    assign out_valid   = out_valid_reg;
    assign hip_angle   = held_hip_reg;
    assign knee_angle  = held_knee_reg;
    assign drive_out   = drive_out_reg;
    assign unreachable = unreachable_reg;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the two-link inverse kinematics block.
`timescale 1ns / 100ps

module tb
    import tlik_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam longint DEG_UNIT = 1048576;

    typedef struct packed {
        logic signed [HIP_W-1:0]  hip;
        logic signed [KNEE_W-1:0] knee;
        logic [DRIVE_W-1:0]       drive;
        logic                     unreach;
    } servo_cmd_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DRIVE_W-1:0]        drive;
        bit                        has_cmd;
        servo_cmd_t                cmd;
    } target_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [2:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic [DRIVE_W-1:0]        drive_level;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [HIP_W-1:0]   hip_angle;
    logic signed [KNEE_W-1:0]  knee_angle;
    logic [DRIVE_W-1:0]        drive_out;
    logic                      unreachable;

    longint     upper_len;
    longint     lower_len;
    longint     held_hip;
    longint     held_knee;
    servo_cmd_t cmd_queue[$];
    int         error_count;
    int         cycle_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    longint     atan_step[24];

    two_link_inverse_kinematics_top uut (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Vectoring arctangent in 2^-20 degree, matching the block's normalization.
    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint mag;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 180 * DEG_UNIT : -180 * DEG_UNIT;
            x = -x;
            y = -y;
        end
        mag = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        while (mag >= (64'sd1 <<< 49))
        begin
            x = floor_shr(x, 1);
            y = floor_shr(y, 1);
            mag = floor_shr(mag, 1);
        end
        while (mag < (64'sd1 <<< 48))
        begin
            x *= 2;
            y *= 2;
            mag *= 2;
        end
        for (int i = 0; i < CORDIC_ITERATIONS_DEF && i < 24; i++)
        begin
            dx = floor_shr(x, i);
            dy = floor_shr(y, i);
            if (y > 0)
            begin
                x += dy;
                y -= dx;
                z += atan_step[i];
            end
            else if (y < 0)
            begin
                x -= dy;
                y += dx;
                z -= atan_step[i];
            end
        end
        return z;
    endfunction

    function automatic servo_cmd_t predict_servo_cmd(longint x, longint y, logic [7:0] drive);
        servo_cmd_t c;
        longint num;
        longint den;
        longint s;
        longint q1;
        longint q2;
        num = x * x + y * y - upper_len * upper_len - lower_len * lower_len;
        den = 2 * upper_len * lower_len;
        c.unreach = 1'b1;
        if (!(den == 0 || num > den || num < -den))
        begin
            c.unreach = 1'b0;
            while (den <= (64'sd1 <<< 30))
            begin
                den *= 2;
                num *= 2;
            end
            s = isqrt(longint'(den * den - num * num));
            q2 = floor_shr(vector_angle(s, num) + 8192, 14);
            q1 = floor_shr(vector_angle(y, x)
                 - vector_angle(lower_len * s, upper_len * den + lower_len * num) + 8192, 14);
            if (q2 < 0)
                q2 = 0;
            if (q2 > HALF_TURN_64)
                q2 = HALF_TURN_64;
            held_hip = q1 - QUARTER_TURN_64;
            if (held_hip > 32767)
                held_hip = 32767;
            if (held_hip < -32768)
                held_hip = -32768;
            held_knee = QUARTER_TURN_64 - q2;
        end
        c.hip = HIP_W'(held_hip);
        c.knee = KNEE_W'(held_knee);
        c.drive = drive;
        return c;
    endfunction

    task automatic write_link(reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_UPPER)
            upper_len = value & 32'h7FFF;
        else
            lower_len = value & 32'h7FFF;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (cmd_queue.size() != 0)
            @(posedge clk);
        // Leave the block idle for a while before the link lengths change.
        repeat (200) @(posedge clk);
    endtask

    task automatic send_target(logic [15:0] x, logic [15:0] y, logic [7:0] drive,
                               bit has_cmd, servo_cmd_t cmd);
        servo_cmd_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        target_x <= x;
        target_y <= y;
        drive_level <= drive;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_servo_cmd(longint'($signed(x)), longint'($signed(y)), drive);
        if (has_cmd && predicted != cmd)
        begin
            $error("table row disagrees with predictor: %h vs %h", cmd, predicted);
            error_count++;
        end
        cmd_queue.push_back(predicted);
    endtask

    task automatic random_targets(int count);
        longint reach;
        int r;
        logic [15:0] x;
        logic [15:0] y;
        for (int n = 0; n < count; n++)
        begin
            reach = upper_len + lower_len;
            if (reach > 32767)
                reach = 32767;
            r = $urandom_range(9);
            if (r < 7)
            begin
                x = 16'($signed($urandom_range(2 * reach)) - reach);
                y = 16'($signed($urandom_range(2 * reach)) - reach);
            end
            else
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            send_target(x, y, 8'($urandom), 1'b0, '0);
            if (n == count / 2)
                drain_results();
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        servo_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (cmd_queue.size() == 0)
            begin
                $error("result with no transaction pending");
                error_count++;
            end
            else
            begin
                want = cmd_queue.pop_front();
                if (hip_angle !== want.hip)
                begin
                    $error("hip_angle expected %0d actual %0d", want.hip, hip_angle);
                    error_count++;
                end
                if (knee_angle !== want.knee)
                begin
                    $error("knee_angle expected %0d actual %0d", want.knee, knee_angle);
                    error_count++;
                end
                if (drive_out !== want.drive)
                begin
                    $error("drive_out expected %0d actual %0d", want.drive, drive_out);
                    error_count++;
                end
                if (unreachable !== want.unreach)
                begin
                    $error("unreachable expected %0d actual %0d", want.unreach, unreachable);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        target_row_t rows[$];
        target_row_t row;
        atan_step = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                      469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                      917, 458, 229, 115, 57, 29, 14, 7};
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 28;
        recv_idle_pct = 62;
        upper_len = 1024;
        lower_len = 1024;
        held_hip = 0;
        held_knee = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        target_x = '0;
        target_y = '0;
        drive_level = '0;
        out_ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: out of reach repeats the reset angles, others use the predictor.
        rows.push_back('{16'sh7FFF, 16'sh7FFF, 8'hFF, 1'b1, '{16'sd0, 14'sd0, 8'hFF, 1'b1}});
        rows.push_back('{-16'sh8000, -16'sh8000, 8'h00, 1'b1,
                         '{16'sd0, 14'sd0, 8'h00, 1'b1}});
        rows.push_back('{16'sd0, 16'sd0, 8'h55, 1'b0, '0});
        rows.push_back('{16'sd2048, 16'sd0, 8'hAA, 1'b0, '0});
        rows.push_back('{16'sd0, 16'sd2048, 8'h01, 1'b0, '0});
        rows.push_back('{-16'sd2048, 16'sd0, 8'h80, 1'b0, '0});
        rows.push_back('{16'sd0, -16'sd2048, 8'h7F, 1'b0, '0});
        rows.push_back('{-16'sd1000, -16'sd1000, 8'h10, 1'b0, '0});
        rows.push_back('{16'sd1448, 16'sd1448, 8'h20, 1'b0, '0});
        rows.push_back('{16'sd3000, 16'sd3000, 8'h33, 1'b0, '0});
        rows.push_back('{-16'sd700, 16'sd900, 8'hFE, 1'b0, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            send_target(row.x, row.y, row.drive, row.has_cmd, row.cmd);
        end
        random_targets(130);

        drain_results();
        write_link(REG_UPPER, 32'd32767);
        write_link(REG_LOWER, 32'd1);
        send_idle_pct = 62;
        recv_idle_pct = 28;
        send_target(16'sh7FFF, 16'sd0, 8'h44, 1'b0, '0);
        send_target(-16'sh8000, 16'sd0, 8'h45, 1'b0, '0);
        random_targets(90);

        drain_results();
        write_link(REG_UPPER, 32'd1);
        write_link(REG_LOWER, 32'd32767);
        random_targets(40);

        drain_results();
        write_link(REG_UPPER, 32'd3);
        write_link(REG_LOWER, 32'd5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_target(16'sd8, 16'sd0, 8'h66, 1'b0, '0);
        send_target(16'sd2, 16'sd0, 8'h67, 1'b0, '0);
        random_targets(50);

        drain_results();
        write_link(REG_UPPER, 32'd1500);
        write_link(REG_LOWER, 32'd900);
        random_targets(90);

        drain_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
